>>> design/wsf_pkg.sv
`default_nettype none

package wsf_pkg;

  // fixed field and register widths
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned FW_W      = 11;
  localparam int unsigned FH_W      = 12;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LINE_DW   = 2 * PIX_W;

  // register reset values and default line capacity
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned RESET_WIDTH   = 640;
  localparam int unsigned RESET_HEIGHT  = 480;
  localparam int unsigned MIN_DIM       = 3;

  // kernel arithmetic: 8*centre plus eight neighbours, then divide by 16
  localparam int unsigned CENTRE_SHIFT = 3;
  localparam int unsigned NORM_SHIFT   = 4;
  localparam int unsigned SUM_W        = PIX_W + NORM_SHIFT;

  // result queue
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // one accepted beat as seen by the datapath
  typedef struct packed {
    logic             valid;
    logic             emit;
    logic             border;
    logic             last;
    logic [PIX_W-1:0] pixel;
  } wsf_item_t;

  // control status towards the top level
  typedef struct packed {
    logic busy;
    logic col_ok;
  } wsf_status_t;

endpackage

`default_nettype wire

>>> design/weighted_3x3_smoothing_filter_core.sv
`default_nettype none

// channel   | dir | tdata         | tuser | tlast
// ----------+-----+---------------+-------+-----------
// s_axis    | in  | pixel_in[7:0] | pad   | -
// m_axis    | out | pixel_out[7:0]| -     | frame_last
// cfg       | in  | cfg_data_i: frame_width (idx 0) / frame_height (idx 1)
//
// one beat per cycle while no rebuild runs and the result queue has room; the
// beat that completes a window goes through line store read, window shift, kernel sum
// each line store entry is read and written once per beat on separate ports
// a config write stalls s_axis (one division step per output position
// bit) while the output row and column are rebuilt from the position
// reset clears counters and registers; line stores are never cleared
// s_axis_tready drops when the four-entry result queue has no room left

module weighted_3x3_smoothing_filter_core #(
  parameter int unsigned MAX_WIDTH = wsf_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // cfg
  input  logic                           cfg_we_i,
  input  logic [wsf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wsf_pkg::CFG_W-1:0]      cfg_data_i,
  // pixel input
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [wsf_pkg::PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel_in
  input  logic                           s_axis_tuser,   // [0] pad
  // pixel output
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [wsf_pkg::PIX_W-1:0]      m_axis_tdata,   // [7:0] pixel_out
  output logic                           m_axis_tlast
);

  import wsf_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  wsf_item_t            item;
  wsf_status_t          status;
  logic                 s_fire;
  logic [AW-1:0]        rd_addr;
  logic [LINE_DW-1:0]   rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [LINE_DW-1:0]   wr_data;
  logic                 push;
  logic [PIX_W-1:0]     push_pixel;
  logic                 push_last;
  logic [1:0]           inflight;
  logic [OUT_CNT_W-1:0] fifo_cnt;
  logic [OUT_CNT_W:0]   committed;

  // room in the result queue for every beat still in the pipe
  assign committed     = (OUT_CNT_W + 1)'(fifo_cnt) + (OUT_CNT_W + 1)'(inflight);
  assign s_axis_tready = !status.busy && (committed < (OUT_CNT_W + 1)'(OUT_DEPTH));
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  wsf_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_fire_i  (s_fire),
    .pixel_i    (s_axis_tdata),
    .pad_i      (s_axis_tuser),
    .rd_addr_o  (rd_addr),
    .item_o     (item),
    .status_o   (status)
  );

  wsf_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (LINE_DW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (item.valid),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  wsf_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .col_i        (rd_addr),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .push_o       (push),
    .push_pixel_o (push_pixel),
    .push_last_o  (push_last),
    .inflight_o   (inflight)
  );

  wsf_out_fifo u_out_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_pixel_i (push_pixel),
    .push_last_i  (push_last),
    .count_o      (fifo_cnt),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .pixel_o      (m_axis_tdata),
    .last_o       (m_axis_tlast)
  );

  // queue never written while full unless an entry leaves in the same cycle
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !(m_axis_tvalid && m_axis_tready)) |-> (fifo_cnt < OUT_CNT_W'(OUT_DEPTH)))
    else $error("result queue overflow");

  // a register write holds off input while row and column are rebuilt
  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("input accepted straight after a register write");

  // output column stays inside the row whenever the block runs
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !status.busy |-> status.col_ok)
    else $error("output column beyond frame width");

endmodule

`default_nettype wire

>>> design/wsf_line_mem.sv
`default_nettype none

module wsf_line_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] line_mem [DEPTH];
  logic [DW-1:0] rd_q;
  logic [DW-1:0] fwd_q;
  logic          fwd_hit_q;

  // storage with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      line_mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q  <= line_mem[rd_addr_i];
      fwd_q <= wr_data_i;
    end
  end

  // same-entry read and write in one cycle takes the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_hit_q ? fwd_q : rd_q;

endmodule

`default_nettype wire

>>> design/wsf_ctrl.sv
`default_nettype none

module wsf_ctrl #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wsf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wsf_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            in_fire_i,
  input  logic [wsf_pkg::PIX_W-1:0]       pixel_i,
  input  logic                            pad_i,
  output logic [$clog2(MAX_WIDTH)-1:0]    rd_addr_o,
  output wsf_pkg::wsf_item_t              item_o,
  output wsf_pkg::wsf_status_t            status_o
);

  import wsf_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW    = (WW > FW_W) ? WW : FW_W;
  localparam int unsigned POS_W = $clog2(MAX_WIDTH * ((1 << FH_W) - 1) + 1);
  localparam int unsigned PW    = WW + FH_W;
  localparam int unsigned CNT_W = $clog2(POS_W + 1);

  typedef enum logic {ST_RUN, ST_DIV} st_e;

  st_e              st_q;
  logic [FW_W-1:0]  fw_q;
  logic [FH_W-1:0]  fh_q;
  logic [AW-1:0]    in_col_q;
  logic [FH_W-1:0]  in_row_q;
  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] orow_q;
  logic [WW-1:0]    ocol_q;
  logic [POS_W-1:0] total_q;
  logic [CNT_W-1:0] div_cnt_q;
  logic [POS_W-1:0] div_quot_q;
  logic [WW-1:0]    div_rem_q;

  logic [WW-1:0]    w_eff;
  logic [FH_W-1:0]  h_eff;
  logic [FH_W-1:0]  h_m1;
  logic [PW-1:0]    area;
  logic             flushing;
  logic             act;
  logic             emit;
  logic             last;
  logic             border;
  logic             col_wrap;
  logic             ocol_wrap;
  logic [WW:0]      rem_sh;
  logic             rem_ge;
  logic [WW:0]      rem_sub;
  logic [WW-1:0]    rem_nx;

  // clamp the frame size registers
  always_comb begin
    if (fw_q < FW_W'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (CW'(fw_q) > CW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_q);
    end
    h_eff = (fh_q < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : fh_q;
  end

  assign h_m1 = h_eff - FH_W'(1);
  assign area = PW'(w_eff) * PW'(h_eff);

  // beat classification
  assign flushing  = in_row_q >= h_eff;
  assign act       = in_fire_i && (flushing || !pad_i);
  assign emit      = flushing || (in_row_q >= FH_W'(2))
                   || ((in_row_q == FH_W'(1)) && (in_col_q != '0));
  assign col_wrap  = ((WW + 1)'(in_col_q) + (WW + 1)'(1)) >= (WW + 1)'(w_eff);
  assign ocol_wrap = ((WW + 1)'(ocol_q) + (WW + 1)'(1)) >= (WW + 1)'(w_eff);
  assign last      = ((POS_W + 1)'(pos_q) + (POS_W + 1)'(1)) >= (POS_W + 1)'(total_q);
  assign border    = (orow_q == '0) || (orow_q >= POS_W'(h_m1))
                   || (ocol_q == '0) || (ocol_q >= (w_eff - WW'(1)));

  // one restoring division step: output position over width
  assign rem_sh  = {div_rem_q, div_quot_q[POS_W-1]};
  assign rem_ge  = rem_sh >= (WW + 1)'(w_eff);
  assign rem_sub = rem_sh - (WW + 1)'(w_eff);
  assign rem_nx  = rem_ge ? rem_sub[WW-1:0] : rem_sh[WW-1:0];

  // frame area for the end-of-frame test
  always_ff @(posedge clk_i) begin
    total_q <= area[POS_W-1:0];
  end

  // registers, counters and the row/column recompute sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_RUN;
      fw_q       <= FW_W'(RESET_WIDTH);
      fh_q       <= FH_W'(RESET_HEIGHT);
      in_col_q   <= '0;
      in_row_q   <= '0;
      pos_q      <= '0;
      orow_q     <= '0;
      ocol_q     <= '0;
      div_cnt_q  <= '0;
      div_quot_q <= '0;
      div_rem_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_FRAME_WIDTH) begin
        fw_q <= cfg_data_i[FW_W-1:0];
      end
      if (cfg_idx_i == REG_FRAME_HEIGHT) begin
        fh_q <= cfg_data_i[FH_W-1:0];
      end
      st_q       <= ST_DIV;
      div_cnt_q  <= CNT_W'(POS_W);
      div_quot_q <= pos_q;
      div_rem_q  <= '0;
    end else begin
      unique case (st_q)
        ST_DIV: begin
          div_quot_q <= {div_quot_q[POS_W-2:0], rem_ge};
          div_rem_q  <= rem_nx;
          div_cnt_q  <= div_cnt_q - CNT_W'(1);
          if (div_cnt_q == CNT_W'(1)) begin
            orow_q <= {div_quot_q[POS_W-2:0], rem_ge};
            ocol_q <= rem_nx;
            st_q   <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (act) begin
            if (emit && last) begin
              in_col_q <= '0;
              in_row_q <= '0;
              pos_q    <= '0;
              orow_q   <= '0;
              ocol_q   <= '0;
            end else begin
              if (col_wrap) begin
                in_col_q <= '0;
                if (!flushing) begin
                  in_row_q <= in_row_q + FH_W'(1);
                end
              end else begin
                in_col_q <= in_col_q + AW'(1);
              end
              if (emit) begin
                pos_q <= pos_q + POS_W'(1);
                if (ocol_wrap) begin
                  ocol_q <= '0;
                  orow_q <= orow_q + POS_W'(1);
                end else begin
                  ocol_q <= ocol_q + WW'(1);
                end
              end
            end
          end
        end
        default: st_q <= ST_RUN;
      endcase
    end
  end

  // beat handed to the window stage, line store read issued now
  always_comb begin
    item_o.valid  = act;
    item_o.emit   = emit;
    item_o.border = border;
    item_o.last   = emit && last;
    item_o.pixel  = flushing ? '0 : pixel_i;
  end

  assign rd_addr_o       = in_col_q;
  assign status_o.busy   = (st_q == ST_DIV);
  assign status_o.col_ok = ocol_q < w_eff;

endmodule

`default_nettype wire

>>> design/wsf_window.sv
`default_nettype none

module wsf_window #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wsf_pkg::wsf_item_t              item_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]    col_i,
  input  logic [wsf_pkg::LINE_DW-1:0]     rd_data_i,
  output logic                            wr_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0]    wr_addr_o,
  output logic [wsf_pkg::LINE_DW-1:0]     wr_data_o,
  output logic                            push_o,
  output logic [wsf_pkg::PIX_W-1:0]       push_pixel_o,
  output logic                            push_last_o,
  output logic [1:0]                      inflight_o
);

  import wsf_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  wsf_item_t        s1_q;
  logic [AW-1:0]    s1_col_q;
  logic             s2_push_q;
  logic             s2_border_q;
  logic             s2_last_q;
  logic [PIX_W-1:0] win_q [3][3];
  logic [PIX_W-1:0] above;
  logic [PIX_W-1:0] middle;
  logic [SUM_W-1:0] sum;

  // line store entry: above row in the upper byte, middle row in the lower
  assign above  = rd_data_i[LINE_DW-1:PIX_W];
  assign middle = rd_data_i[PIX_W-1:0];

  // write back: middle moves up, the new pixel becomes the middle row
  assign wr_en_o   = s1_q.valid;
  assign wr_addr_o = s1_col_q;
  assign wr_data_o = {middle, s1_q.pixel};

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= '0;
      s2_push_q <= 1'b0;
    end else begin
      s1_q      <= item_i;
      s2_push_q <= s1_q.valid && s1_q.emit;
    end
  end

  // sideband and address along the pipe
  always_ff @(posedge clk_i) begin
    s1_col_q    <= col_i;
    s2_border_q <= s1_q.border;
    s2_last_q   <= s1_q.last;
  end

  // 3x3 window shift, new column enters on the right
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (s1_q.valid) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= above;
      win_q[1][2] <= middle;
      win_q[2][2] <= s1_q.pixel;
    end
  end

  // weighted sum over the window
  assign sum = (SUM_W'(win_q[1][1]) << CENTRE_SHIFT)
             + SUM_W'(win_q[0][0]) + SUM_W'(win_q[0][1]) + SUM_W'(win_q[0][2])
             + SUM_W'(win_q[1][0]) + SUM_W'(win_q[1][2])
             + SUM_W'(win_q[2][0]) + SUM_W'(win_q[2][1]) + SUM_W'(win_q[2][2]);

  assign push_o       = s2_push_q;
  assign push_pixel_o = s2_border_q ? win_q[1][1] : sum[SUM_W-1:NORM_SHIFT];
  assign push_last_o  = s2_last_q;
  assign inflight_o   = 2'(s1_q.valid && s1_q.emit) + 2'(s2_push_q);

endmodule

`default_nettype wire

>>> design/wsf_out_fifo.sv
`default_nettype none

module wsf_out_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [wsf_pkg::PIX_W-1:0]      push_pixel_i,
  input  logic                           push_last_i,
  output logic [wsf_pkg::OUT_CNT_W-1:0]  count_o,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [wsf_pkg::PIX_W-1:0]      pixel_o,
  output logic                           last_o
);

  import wsf_pkg::*;

  logic [PIX_W:0]     slot_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q;
  logic [OUT_PTR_W-1:0] rd_ptr_q;
  logic [OUT_CNT_W-1:0] cnt_q;
  logic                 pop;

  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;

  // result slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= {push_last_i, push_pixel_i};
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + OUT_CNT_W'(1);
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - OUT_CNT_W'(1);
      end
    end
  end

  assign pixel_o = slot_q[rd_ptr_q][PIX_W-1:0];
  assign last_o  = slot_q[rd_ptr_q][PIX_W];
  assign count_o = cnt_q;

endmodule

`default_nettype wire
